// ===== rtl/cura_pkg.sv =====
// Shared types, codes and helpers for the confirmed uplink retry / ADR block.
package cura_pkg;

  // Default parameter values
  localparam int SEQ_BITS_DEF = 16;
  localparam int MAX_SF_DEF   = 12;

  // Fixed field widths
  localparam int FRAME_SEQ_W = 16;
  localparam int VALUE_W     = 31;
  localparam int ADR_CNT_W   = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  // Event kinds
  localparam logic [1:0] KIND_NEW     = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_CONFIG  = 2'd2;
  localparam logic [1:0] KIND_ACK     = 2'd3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_LIMIT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ADAPT_ENABLE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REQ_LIMIT     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_DELAY = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_SF    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_TP    = 3'd5;

  // Register reset values
  localparam logic [3:0] RETRY_LIMIT_RST   = 4'd8;
  localparam logic       ADAPT_ENABLE_RST  = 1'b1;
  localparam logic [7:0] REQ_LIMIT_RST     = 8'd64;
  localparam logic [7:0] BACKOFF_DELAY_RST = 8'd32;
  localparam logic [3:0] INITIAL_SF_RST    = 4'd12;
  localparam logic [3:0] INITIAL_TP_RST    = 4'd14;

  // Radio limits
  localparam logic [3:0] SF_MIN    = 4'd7;
  localparam logic [3:0] TP_MIN    = 4'd2;
  localparam logic [3:0] TP_MAX    = 4'd14;
  localparam logic [3:0] RETRY_SAT = 4'd15;

  typedef struct packed {
    logic [3:0] retry_limit;
    logic       adapt_enable;
    logic [7:0] req_limit;
    logic [7:0] backoff_delay;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_W-1:0]   last_value;
    logic [3:0]           retry_count;
    logic                 ack_pending;
    logic [ADR_CNT_W-1:0] adr_count;
    logic                 adr_req_flag;
    logic [3:0]           cur_sf;
    logic [3:0]           cur_tp;
  } state_t;

  typedef struct packed {
    logic                   frame_sent;
    logic                   is_retransmit;
    logic [FRAME_SEQ_W-1:0] frame_seq;
    logic [VALUE_W-1:0]     frame_value;
    logic [3:0]             frame_sf;
    logic [3:0]             frame_tp;
    logic                   adr_ack_req;
    logic                   gave_up;
    logic                   waiting_ack;
  } result_t;

  // Saturate a spreading factor to SF_MIN..hi
  function automatic logic [3:0] clamp_sf(input logic [3:0] v, input logic [3:0] hi);
    logic [3:0] r;
    r = v;
    if (v < SF_MIN) r = SF_MIN;
    else if (v > hi) r = hi;
    return r;
  endfunction

  // Saturate a power to TP_MIN..TP_MAX
  function automatic logic [3:0] clamp_tp(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    if (v < TP_MIN) r = TP_MIN;
    else if (v > TP_MAX) r = TP_MAX;
    return r;
  endfunction

endpackage

// ===== rtl/cura_step.sv =====
// Event logic: next state and result item for one event.
module cura_step #(
  parameter int SEQ_BITS = cura_pkg::SEQ_BITS_DEF,
  parameter int MAX_SF   = cura_pkg::MAX_SF_DEF
) (
  input  cura_pkg::cfg_t          cfg,
  input  cura_pkg::state_t        state,
  input  logic [SEQ_BITS-1:0]     seq,
  input  logic [1:0]              kind,
  input  logic [30:0]             sample_value,
  input  logic signed [4:0]       cmd_sf,
  input  logic signed [4:0]       cmd_tp,
  output cura_pkg::state_t        state_next,
  output logic [SEQ_BITS-1:0]     seq_next,
  output cura_pkg::result_t       result
);
  import cura_pkg::*;

  localparam logic [3:0] MaxSf = 4'(MAX_SF);

  logic                  send;
  logic                  retx;
  logic                  gave_up;
  logic                  req;
  logic [SEQ_BITS-1:0]   frame_seq_raw;
  logic [3:0]            bumped;
  logic [ADR_CNT_W-1:0]  adr_cnt;
  logic [ADR_CNT_W-1:0]  adr_sum;

  assign adr_sum = {1'b0, cfg.req_limit} + {1'b0, cfg.backoff_delay};

  always_comb begin
    state_next    = state;
    seq_next      = seq;
    send          = 1'b0;
    retx          = 1'b0;
    gave_up       = 1'b0;
    req           = 1'b0;
    frame_seq_raw = seq;
    bumped        = state.retry_count;
    adr_cnt       = state.adr_count;

    // Decode the event
    unique case (kind)
      KIND_NEW: begin
        state_next.last_value  = sample_value;
        state_next.retry_count = 4'd0;
        state_next.ack_pending = 1'b1;
        send                   = 1'b1;
        seq_next               = seq + SEQ_BITS'(1);
      end
      KIND_TIMEOUT: begin
        if (state.ack_pending) begin
          if (state.retry_count != RETRY_SAT) bumped = state.retry_count + 4'd1;
          if (bumped < cfg.retry_limit) begin
            state_next.retry_count = bumped;
            send                   = 1'b1;
            retx                   = 1'b1;
            frame_seq_raw          = seq - SEQ_BITS'(1);
          end else begin
            gave_up                = 1'b1;
            state_next.ack_pending = 1'b0;
            state_next.retry_count = 4'd0;
          end
        end
      end
      KIND_CONFIG: begin
        if (cfg.adapt_enable) begin
          state_next.adr_count = '0;
          if (!cmd_tp[4]) state_next.cur_tp = clamp_tp(cmd_tp[3:0]);
          if (!cmd_sf[4]) state_next.cur_sf = clamp_sf(cmd_sf[3:0], MaxSf);
        end
      end
      default: begin
        state_next.ack_pending = 1'b0;
      end
    endcase

    // Count the frame toward the ADR limits
    if (send && cfg.adapt_enable) begin
      req                     = state.adr_req_flag;
      state_next.adr_req_flag = 1'b0;
      adr_cnt                 = state.adr_count + ADR_CNT_W'(1);
      if (adr_cnt == {1'b0, cfg.req_limit}) state_next.adr_req_flag = 1'b1;
      if (adr_cnt >= adr_sum) begin
        adr_cnt = '0;
        if (state.cur_sf < MaxSf) state_next.cur_sf = state.cur_sf + 4'd1;
      end
      state_next.adr_count = adr_cnt;
    end

    // Build the result item; frame fields stay zero without a frame
    result.frame_sent    = send;
    result.is_retransmit = retx;
    result.frame_seq     = send ? FRAME_SEQ_W'(frame_seq_raw) : '0;
    result.frame_value   = send ? state_next.last_value : '0;
    result.frame_sf      = send ? state.cur_sf : 4'd0;
    result.frame_tp      = send ? state.cur_tp : 4'd0;
    result.adr_ack_req   = req;
    result.gave_up       = gave_up;
    result.waiting_ack   = state_next.ack_pending;
  end

endmodule

// ===== rtl/confirmed_uplink_retry_adr.sv =====
// Top level: confirmed uplink retry and ADR backoff with registered in and out.
//
// Takes one event item per clock while the output is not stalled and returns exactly
// one result item for each, through the input register and then the result register.
// The event logic sits between those two registers and updates the
// node state in the same cycle that the result is registered, so back-to-back
// events see the state left by the one before. A full result register with a
// stalled output holds the input register; in_ready stays high while either
// has room.
// Configuration writes are taken at once (cfg_ready is always high); writing
// initial_sf or initial_tp also reloads the current spreading factor or power.
// Write configuration only while no event is in flight.
module confirmed_uplink_retry_adr #(
  parameter int SEQ_BITS = cura_pkg::SEQ_BITS_DEF,
  parameter int MAX_SF   = cura_pkg::MAX_SF_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // Configuration write
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [cura_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cura_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Event input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           kind,
  input  logic [30:0]                          sample_value,
  input  logic signed [4:0]                    cmd_sf,
  input  logic signed [4:0]                    cmd_tp,
  // Result output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic                                 frame_sent,
  output logic                                 is_retransmit,
  output logic [15:0]                          frame_seq,
  output logic [30:0]                          frame_value,
  output logic [3:0]                           frame_sf,
  output logic [3:0]                           frame_tp,
  output logic                                 adr_ack_req,
  output logic                                 gave_up,
  output logic                                 waiting_ack
);
  import cura_pkg::*;

  localparam logic [3:0] MaxSf = 4'(MAX_SF);

  cfg_t                cfg;
  state_t              state;
  state_t              state_next;
  logic [SEQ_BITS-1:0] seq;
  logic [SEQ_BITS-1:0] seq_next;
  result_t             result_next;
  result_t             result;

  logic                inq_valid;
  logic [1:0]          inq_kind;
  logic [30:0]         inq_sample;
  logic signed [4:0]   inq_cmd_sf;
  logic signed [4:0]   inq_cmd_tp;

  logic                advance;
  logic                fire;
  logic                cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;

  // Pipeline control
  assign advance  = ~out_valid | out_ready;
  assign fire     = inq_valid & advance;
  assign in_ready = ~inq_valid | advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inq_valid <= 1'b0;
    end else if (in_ready) begin
      inq_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      inq_kind   <= kind;
      inq_sample <= sample_value;
      inq_cmd_sf <= cmd_sf;
      inq_cmd_tp <= cmd_tp;
    end
  end

  cura_step #(
    .SEQ_BITS (SEQ_BITS),
    .MAX_SF   (MAX_SF)
  ) u_step (
    .cfg          (cfg),
    .state        (state),
    .seq          (seq),
    .kind         (inq_kind),
    .sample_value (inq_sample),
    .cmd_sf       (inq_cmd_sf),
    .cmd_tp       (inq_cmd_tp),
    .state_next   (state_next),
    .seq_next     (seq_next),
    .result       (result_next)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.retry_limit   <= RETRY_LIMIT_RST;
      cfg.adapt_enable  <= ADAPT_ENABLE_RST;
      cfg.req_limit     <= REQ_LIMIT_RST;
      cfg.backoff_delay <= BACKOFF_DELAY_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RETRY_LIMIT:   cfg.retry_limit   <= cfg_data[3:0];
        REG_ADAPT_ENABLE:  cfg.adapt_enable  <= cfg_data[0];
        REG_REQ_LIMIT:     cfg.req_limit     <= cfg_data;
        REG_BACKOFF_DELAY: cfg.backoff_delay <= cfg_data;
        default: ;
      endcase
    end
  end

  // Node state: initial SF/TP writes reload the current values
  always_ff @(posedge clk) begin
    if (rst) begin
      state.last_value   <= '0;
      state.retry_count  <= 4'd0;
      state.ack_pending  <= 1'b0;
      state.adr_count    <= '0;
      state.adr_req_flag <= 1'b0;
      state.cur_sf       <= clamp_sf(INITIAL_SF_RST, MaxSf);
      state.cur_tp       <= clamp_tp(INITIAL_TP_RST);
      seq                <= '0;
    end else if (cfg_we && cfg_index == REG_INITIAL_SF) begin
      state.cur_sf <= clamp_sf(cfg_data[3:0], MaxSf);
    end else if (cfg_we && cfg_index == REG_INITIAL_TP) begin
      state.cur_tp <= clamp_tp(cfg_data[3:0]);
    end else if (fire) begin
      state <= state_next;
      seq   <= seq_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= inq_valid;
    end
    if (fire) begin
      result <= result_next;
    end
  end

  assign frame_sent    = result.frame_sent;
  assign is_retransmit = result.is_retransmit;
  assign frame_seq     = result.frame_seq;
  assign frame_value   = result.frame_value;
  assign frame_sf      = result.frame_sf;
  assign frame_tp      = result.frame_tp;
  assign adr_ack_req   = result.adr_ack_req;
  assign gave_up       = result.gave_up;
  assign waiting_ack   = result.waiting_ack;

endmodule

// ===== verif/tb_uplink_pkg.sv =====
// Result tracker for the confirmed uplink retry / ADR block: next-state prediction and checking.
package tb_uplink_pkg;
  import cura_pkg::*;

  localparam logic [3:0] SF_TOP      = 4'(MAX_SF_DEF);

  class uplink_tracker;
    // register copies
    logic [3:0] retry_limit;
    logic       adapt_en;
    logic [7:0] ack_limit;
    logic [7:0] ack_delay;
    // node state
    logic [FRAME_SEQ_W-1:0] next_seq;
    logic [VALUE_W-1:0]     last_value;
    logic [3:0]             retry_count;
    logic                   ack_pending;
    logic [ADR_CNT_W-1:0]   adr_count;
    logic                   adr_req_flag;
    logic [3:0]             cur_sf;
    logic [3:0]             cur_tp;
    // results still owed by the block, oldest first
    result_t frames_due[$];
    int errors;
    int n_events, n_frames, n_resends, n_gave_up, n_adr_req, n_writes;

    function new();
      retry_limit  = RETRY_LIMIT_RST;
      adapt_en     = ADAPT_ENABLE_RST;
      ack_limit    = REQ_LIMIT_RST;
      ack_delay    = BACKOFF_DELAY_RST;
      next_seq     = '0;
      last_value   = '0;
      retry_count  = '0;
      ack_pending  = 1'b0;
      adr_count    = '0;
      adr_req_flag = 1'b0;
      cur_sf       = saturate(INITIAL_SF_RST, SF_MIN, SF_TOP);
      cur_tp       = saturate(INITIAL_TP_RST, TP_MIN, TP_MAX);
      errors       = 0;
      n_events     = 0;
      n_frames     = 0;
      n_resends    = 0;
      n_gave_up    = 0;
      n_adr_req    = 0;
      n_writes     = 0;
    endfunction

    function logic [3:0] saturate(input logic [3:0] v, input logic [3:0] lo,
                                  input logic [3:0] hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    function logic awaiting();
      return ack_pending;
    endfunction

    function int outstanding();
      return frames_due.size();
    endfunction

    // Apply one register write
    function void write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
      n_writes++;
      case (idx)
        REG_RETRY_LIMIT:   retry_limit = data[3:0];
        REG_ADAPT_ENABLE:  adapt_en    = data[0];
        REG_REQ_LIMIT:     ack_limit   = data;
        REG_BACKOFF_DELAY: ack_delay   = data;
        REG_INITIAL_SF:    cur_sf      = saturate(data[3:0], SF_MIN, SF_TOP);
        REG_INITIAL_TP:    cur_tp      = saturate(data[3:0], TP_MIN, TP_MAX);
        default: ;
      endcase
    endfunction

    // Fill in a frame and, with ADR on, advance the ADR counting that the frame causes
    function void emit_frame(inout result_t r, input logic [FRAME_SEQ_W-1:0] seq,
                             input logic retx);
      r.frame_sent    = 1'b1;
      r.is_retransmit = retx;
      r.frame_seq     = seq;
      r.frame_value   = last_value;
      r.frame_sf      = cur_sf;
      r.frame_tp      = cur_tp;
      n_frames++;
      if (retx) n_resends++;
      if (adapt_en) begin
        if (adr_req_flag) begin
          r.adr_ack_req = 1'b1;
          adr_req_flag  = 1'b0;
          n_adr_req++;
        end
        adr_count = adr_count + 9'd1;
        if (adr_count == {1'b0, ack_limit}) adr_req_flag = 1'b1;
        if (adr_count >= {1'b0, ack_limit} + {1'b0, ack_delay}) begin
          adr_count = '0;
          if (cur_sf < SF_TOP) cur_sf = cur_sf + 4'd1;
        end
      end
    endfunction

    // Predict the result of one accepted event item and queue it
    function void take_event(input logic [1:0] k, input logic [VALUE_W-1:0] v,
                             input logic [4:0] s, input logic [4:0] t);
      result_t r;
      r = '0;
      n_events++;
      case (k)
        KIND_NEW: begin
          last_value  = v;
          retry_count = '0;
          ack_pending = 1'b1;
          emit_frame(r, next_seq, 1'b0);
          next_seq = next_seq + 1'b1;
        end
        KIND_TIMEOUT: begin
          if (ack_pending) begin
            if (retry_count != RETRY_SAT) retry_count = retry_count + 4'd1;
            if (retry_count < retry_limit) begin
              emit_frame(r, next_seq - 1'b1, 1'b1);
            end else begin
              r.gave_up   = 1'b1;
              ack_pending = 1'b0;
              retry_count = '0;
              n_gave_up++;
            end
          end
        end
        KIND_CONFIG: begin
          if (adapt_en) begin
            adr_count = '0;
            if (!t[4]) cur_tp = saturate(t[3:0], TP_MIN, TP_MAX);
            if (!s[4]) cur_sf = saturate(s[3:0], SF_MIN, SF_TOP);
          end
        end
        default: ack_pending = 1'b0;
      endcase
      r.waiting_ack = ack_pending;
      frames_due.push_back(r);
    endfunction

    function void compare(input string nm, input logic [31:0] e, input logic [31:0] a);
      if (e !== a) begin
        errors++;
        $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, nm, e, a);
      end
    endfunction

    // Check one accepted result item against the oldest prediction
    function void match_result(input result_t got);
      result_t e;
      if (frames_due.size() == 0) begin
        errors++;
        $display("%0t: result item with no event outstanding", $time);
        return;
      end
      e = frames_due.pop_front();
      compare("frame_sent",    e.frame_sent,    got.frame_sent);
      compare("is_retransmit", e.is_retransmit, got.is_retransmit);
      compare("frame_seq",     e.frame_seq,     got.frame_seq);
      compare("frame_value",   e.frame_value,   got.frame_value);
      compare("frame_sf",      e.frame_sf,      got.frame_sf);
      compare("frame_tp",      e.frame_tp,      got.frame_tp);
      compare("adr_ack_req",   e.adr_ack_req,   got.adr_ack_req);
      compare("gave_up",       e.gave_up,       got.gave_up);
      compare("waiting_ack",   e.waiting_ack,   got.waiting_ack);
    endfunction
  endclass

endpackage

// ===== verif/tb_top.sv =====
// Top-level testbench for confirmed_uplink_retry_adr: stimulus, stalls and end-of-run report.
module tb_top;
  import cura_pkg::*;
  import tb_uplink_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                in_valid     = 1'b0;
  logic                in_ready;
  logic [1:0]          kind         = KIND_ACK;
  logic [30:0]         sample_value = '0;
  logic signed [4:0]   cmd_sf       = '0;
  logic signed [4:0]   cmd_tp       = '0;

  logic        out_valid;
  logic        out_ready = 1'b1;
  logic        frame_sent;
  logic        is_retransmit;
  logic [15:0] frame_seq;
  logic [30:0] frame_value;
  logic [3:0]  frame_sf;
  logic [3:0]  frame_tp;
  logic        adr_ack_req;
  logic        gave_up;
  logic        waiting_ack;

  uplink_tracker tracker;
  int            items_sent = 0;
  int            cycles     = 0;
  int            stall_left = 0;
  bit            idle_on    = 1'b0;

  confirmed_uplink_retry_adr uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .sample_value  (sample_value),
    .cmd_sf        (cmd_sf),
    .cmd_tp        (cmd_tp),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .frame_sent    (frame_sent),
    .is_retransmit (is_retransmit),
    .frame_seq     (frame_seq),
    .frame_value   (frame_value),
    .frame_sf      (frame_sf),
    .frame_tp      (frame_tp),
    .adr_ack_req   (adr_ack_req),
    .gave_up       (gave_up),
    .waiting_ack   (waiting_ack)
  );

  always #5 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Stall the result side in random bursts while idling is on
  always @(posedge clk) begin
    if (stall_left > 1) begin
      stall_left <= stall_left - 1;
    end else if (stall_left == 1) begin
      stall_left <= 0;
      out_ready  <= 1'b1;
    end else if (idle_on && !rst && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 19);
      out_ready  <= 1'b0;
    end
  end

  // Check every result item taken
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready)
      tracker.match_result({frame_sent, is_retransmit, frame_seq, frame_value, frame_sf,
                            frame_tp, adr_ack_req, gave_up, waiting_ack});
  end

  function automatic logic [30:0] rand_value();
    return 31'($urandom);
  endfunction

  // Half the time any 5-bit pattern; otherwise mostly legal commands, sometimes the keep code
  function automatic logic [4:0] rand_cmd(input int hi);
    if ($urandom_range(0, 1) == 0) return 5'($urandom_range(0, 31));
    if ($urandom_range(0, 13) == 0) return 5'h1F;
    return 5'($urandom_range(0, hi));
  endfunction

  // Offer one event item and hold it until taken
  task automatic post_event(input logic [1:0] k, input logic [30:0] v,
                            input logic [4:0] s, input logic [4:0] t);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    kind         <= k;
    sample_value <= v;
    cmd_sf       <= s;
    cmd_tp       <= t;
    do @(posedge clk); while (!in_ready);
    tracker.take_event(k, v, s, t);
    items_sent++;
  endtask

  task automatic post_kind(input logic [1:0] k);
    post_event(k, rand_value(), rand_cmd(12), rand_cmd(14));
  endtask

  // Hold off the sender until every predicted result has come back
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    tracker.write_reg(idx, data);
  endtask

  // Drain, then load a full register set while the block is idle
  task automatic apply_setup(input logic [3:0] rl, input logic ae, input logic [7:0] lim,
                             input logic [7:0] dly, input logic [3:0] sf,
                             input logic [3:0] tp, input bit spare);
    settle();
    write_register(REG_RETRY_LIMIT, {4'($urandom), rl});
    write_register(REG_ADAPT_ENABLE, {7'($urandom), ae});
    write_register(REG_REQ_LIMIT, lim);
    write_register(REG_BACKOFF_DELAY, dly);
    write_register(REG_INITIAL_SF, {4'($urandom), sf});
    write_register(REG_INITIAL_TP, {4'($urandom), tp});
    if (spare) begin
      write_register(REG_SPARE_LO, 8'($urandom));
      write_register(REG_SPARE_HI, 8'($urandom));
    end
    cfg_valid <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Mostly whole exchanges (send, a few timeouts, maybe an ack) plus noise
  task automatic run_traffic(input int count, input int cfg_pct);
    int stop;
    int pick;
    int tries;
    stop = items_sent + count;
    while (items_sent < stop) begin
      pick = $urandom_range(0, 99);
      if (pick < cfg_pct) begin
        post_kind(KIND_CONFIG);
      end else if (pick < cfg_pct + 12) begin
        post_kind(2'($urandom_range(0, 3)));
      end else begin
        post_kind(KIND_NEW);
        tries = $urandom_range(0, 17);
        while (tries > 0 && tracker.awaiting()) begin
          post_kind(KIND_TIMEOUT);
          tries--;
        end
        if ($urandom_range(0, 3) != 0) post_kind(KIND_ACK);
      end
    end
  endtask

  initial begin
    tracker = new();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (2) @(posedge clk);

    // Directed: idle timeout and ack, value extremes, every config form, full give-up
    post_event(KIND_TIMEOUT, 31'h7FFFFFFF, 5'h0F, 5'h0F);
    post_event(KIND_ACK, '0, 5'h10, 5'h10);
    post_event(KIND_NEW, 31'h7FFFFFFF, 5'h1F, 5'h1F);
    post_event(KIND_TIMEOUT, '0, '0, '0);
    post_event(KIND_ACK, '0, '0, '0);
    post_event(KIND_NEW, '0, '0, '0);
    post_event(KIND_CONFIG, '0, 5'h1F, 5'h1F);
    post_event(KIND_CONFIG, '0, 5'd0, 5'd0);
    post_event(KIND_CONFIG, '0, 5'd12, 5'd14);
    post_event(KIND_CONFIG, '0, 5'd15, 5'd15);
    post_event(KIND_CONFIG, '0, 5'h10, 5'h10);
    post_event(KIND_NEW, rand_value(), '0, '0);
    repeat (8) post_event(KIND_TIMEOUT, rand_value(), '0, '0);
    post_event(KIND_TIMEOUT, '0, '0, '0);

    // Defaults from reset, with stalls
    idle_on = 1'b1;
    run_traffic(230, 5);

    // Tightest ADR limits, no retries allowed, lowest radio settings
    apply_setup(4'd0, 1'b1, 8'd1, 8'd1, 4'd7, 4'd2, 1'b0);
    idle_on = 1'b0;
    run_traffic(230, 5);

    // Widest limits, most retries, downlink config only from the noise events to reset the counter
    apply_setup(4'd15, 1'b1, 8'd255, 8'd255, 4'd12, 4'd14, 1'b0);
    idle_on = 1'b1;
    run_traffic(230, 0);

    // ADR off, out of range initial values, spare register indexes
    apply_setup(4'd1, 1'b0, 8'd3, 8'd2, 4'd0, 4'd15, 1'b1);
    run_traffic(230, 10);

    apply_setup(4'd3, 1'b1, 8'd2, 8'd5, 4'd15, 4'd0, 1'b0);
    idle_on = 1'b0;
    run_traffic(230, 5);

    apply_setup(RETRY_LIMIT_RST, ADAPT_ENABLE_RST, REQ_LIMIT_RST, BACKOFF_DELAY_RST,
                INITIAL_SF_RST, INITIAL_TP_RST, 1'b0);
    idle_on = 1'b1;
    run_traffic(230, 5);

    repeat (2) begin
      apply_setup(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)),
                  8'($urandom_range(1, 12)), 8'($urandom_range(1, 12)),
                  4'($urandom_range(7, 12)), 4'($urandom_range(2, 14)), 1'b0);
      run_traffic(200, 5);
    end

    // Closing stretch with no idling on either side
    idle_on = 1'b0;
    apply_setup(4'($urandom_range(0, 15)), 1'b1, 8'($urandom_range(1, 20)),
                8'($urandom_range(1, 20)), 4'($urandom_range(0, 15)),
                4'($urandom_range(0, 15)), 1'b0);
    run_traffic(200, 5);

    settle();
    repeat (10) @(posedge clk);
    $display("Ran %0d events through nine register settings.", tracker.n_events);
    $display("Saw %0d frames (%0d resends), %0d give-ups, %0d ADR requests, %0d writes.",
             tracker.n_frames, tracker.n_resends, tracker.n_gave_up, tracker.n_adr_req,
             tracker.n_writes);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
